FILE: hdl/lre_pkg.sv
// Shared types and constants for the linear ramp envelope block.
`timescale 1ns / 1ps

package lre_pkg;

	localparam int unsigned ValW = 17;
	localparam logic [ValW-1:0] FULL_SCALE = 17'h10000;

	typedef struct packed {
		logic [ValW-1:0] value;
		logic            done;
	} res_t;

endpackage

FILE: hdl/lre_ctrl.sv
// Envelope state and per-request next-state logic.
`timescale 1ns / 1ps

module lre_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [2:0]                func,
	input  logic                      ramp_enable,
	input  logic                      hold_level,
	input  logic [lre_pkg::ValW-1:0]  ramp_step,
	input  logic [31:0]               hold_ticks,
	output lre_pkg::res_t             res
);

	typedef enum logic [2:0] {
		FN_TICK  = 3'd0,
		FN_START = 3'd1,
		FN_STOP  = 3'd2,
		FN_UP    = 3'd3,
		FN_DOWN  = 3'd4,
		FN_FULL  = 3'd5,
		FN_ZERO  = 3'd6,
		FN_HOLD  = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	logic [lre_pkg::ValW-1:0] env_q, env_d;
	dir_t                     dir_q, dir_d;
	logic                     run_q, run_d;
	logic                     rhold_q, rhold_d;
	logic [31:0]              hcnt_q, hcnt_d;
	logic [lre_pkg::ValW-1:0] step;
	logic [lre_pkg::ValW:0]   sum;
	logic                     step_zero;

	assign step_zero = (ramp_step == '0);
	// zero or oversized step acts as a full-scale jump
	assign step = (step_zero || ramp_step > lre_pkg::FULL_SCALE) ? lre_pkg::FULL_SCALE
		: ramp_step;
	assign sum = {1'b0, env_q} + {1'b0, step};

	always_comb begin
		env_d   = env_q;
		dir_d   = dir_q;
		run_d   = run_q;
		rhold_d = rhold_q;
		hcnt_d  = hcnt_q;
		unique case (func_t'(func))
			FN_TICK: begin
				if (!run_q || rhold_q || !ramp_enable) begin
					env_d  = '0;
					dir_d  = DIR_UP;
					hcnt_d = '0;
				end else begin
					if (dir_q == DIR_UP && env_q < lre_pkg::FULL_SCALE) begin
						if (sum >= {1'b0, lre_pkg::FULL_SCALE}) begin
							env_d  = lre_pkg::FULL_SCALE;
							dir_d  = DIR_IDLE;
							hcnt_d = '0;
						end else begin
							env_d = sum[lre_pkg::ValW-1:0];
						end
					end
					if (env_d == lre_pkg::FULL_SCALE && hold_ticks != '0) begin
						if (hcnt_d >= hold_ticks) begin
							if (step_zero) begin
								env_d = '0;
								dir_d = DIR_IDLE;
							end else begin
								dir_d = DIR_DOWN;
							end
						end else begin
							hcnt_d = hcnt_d + 32'd1;
						end
					end
					if (dir_d == DIR_DOWN && env_d != '0) begin
						if (env_d <= step) begin
							env_d = '0;
							dir_d = DIR_IDLE;
						end else begin
							env_d = env_d - step;
						end
					end
				end
			end
			FN_START: begin
				env_d  = '0;
				dir_d  = DIR_UP;
				hcnt_d = '0;
				run_d  = 1'b1;
			end
			FN_STOP: begin
				if (run_q) begin
					run_d  = 1'b0;
					env_d  = '0;
					dir_d  = DIR_UP;
					hcnt_d = '0;
				end
			end
			FN_UP: begin
				if (step_zero) begin
					env_d  = lre_pkg::FULL_SCALE;
					dir_d  = DIR_IDLE;
					hcnt_d = '0;
				end else begin
					dir_d = DIR_UP;
				end
			end
			FN_DOWN: begin
				if (step_zero) begin
					env_d = '0;
					dir_d = DIR_IDLE;
				end else begin
					dir_d = DIR_DOWN;
				end
			end
			FN_FULL: begin
				env_d  = lre_pkg::FULL_SCALE;
				dir_d  = DIR_IDLE;
				hcnt_d = '0;
			end
			FN_ZERO: begin
				env_d = '0;
				dir_d = DIR_IDLE;
			end
			FN_HOLD: begin
				rhold_d = hold_level;
				if (hold_level) begin
					env_d  = '0;
					dir_d  = DIR_UP;
					hcnt_d = '0;
				end
			end
		endcase
	end

	always_comb begin
		res.value = run_d ? env_d : '0;
		res.done  = !((dir_d == DIR_UP && env_d < lre_pkg::FULL_SCALE) ||
			(dir_d == DIR_DOWN && env_d != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q   <= '0;
			dir_q   <= DIR_IDLE;
			run_q   <= 1'b0;
			rhold_q <= 1'b0;
			hcnt_q  <= '0;
		end else if (accept) begin
			env_q   <= env_d;
			dir_q   <= dir_d;
			run_q   <= run_d;
			rhold_q <= rhold_d;
			hcnt_q  <= hcnt_d;
		end
	end

`ifndef SYNTHESIS
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= lre_pkg::FULL_SCALE)
		else $error("envelope above full scale");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FN_START |=> run_q && env_q == '0)
		else $error("start did not arm the envelope");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FN_STOP |=> !run_q)
		else $error("stop left the block running");

	a_hold_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FN_TICK && rhold_q |=> env_q == '0 && dir_q == DIR_UP)
		else $error("tick under reset hold moved the envelope");
`endif

endmodule

FILE: hdl/lre_scale.sv
// Result pipeline: operand times envelope, truncation, output register.
`timescale 1ns / 1ps

module lre_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lre_pkg::res_t             res,
	input  logic signed [31:0]        operand,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lre_pkg::ValW-1:0]  ramp_value,
	output logic                      ramp_done,
	output logic signed [31:0]        scaled
);

	logic                      v_s1, v_s2, out_v_q;
	logic                      ld1, ld2, ld_out;
	lre_pkg::res_t             res_s1, res_s2, res_q;
	logic signed [31:0]        op_s1;
	logic signed [49:0]        prod_s2;
	logic [49:0]               adj;
	logic [31:0]               scaled_q;

	assign ld_out   = !out_v_q || out_ready;
	assign ld2      = !v_s2 || ld_out;
	assign ld1      = !v_s1 || ld2;
	assign in_ready = ld1;

	// bias negatives so the shift truncates toward zero
	assign adj = prod_s2 + {34'd0, {16{prod_s2[49]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld_out) out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			res_s1 <= res;
			op_s1  <= operand;
		end
		if (ld2 && v_s1) begin
			res_s2  <= res_s1;
			prod_s2 <= $signed({1'b0, res_s1.value}) * op_s1;
		end
		if (ld_out && v_s2) begin
			res_q    <= res_s2;
			scaled_q <= adj[47:16];
		end
	end

	assign out_valid  = out_v_q;
	assign ramp_value = res_q.value;
	assign ramp_done  = res_q.done;
	assign scaled     = scaled_q;

`ifndef SYNTHESIS
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ramp_value == '0 |-> scaled == '0)
		else $error("zero envelope gave nonzero product");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ramp_value <= lre_pkg::FULL_SCALE)
		else $error("result envelope above full scale");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ld_out |=> v_s2 && out_v_q)
		else $error("stalled request lost in pipeline");
`endif

endmodule

FILE: hdl/linear_ramp_envelope_with_hold.sv
// Top level: register port, envelope control and result pipeline.
`timescale 1ns / 1ps

// Gain envelope in unsigned Q1.16 that ramps from zero to full scale, holds for
// hold_ticks ticks (forever if zero) and ramps back down, driven by one tick or
// command per request. One request is accepted every clock cycle while in_ready
// is high; the envelope state updates in the accept cycle itself, so back-to-back
// requests see each other's effect. Each result passes the control result
// register, the 18x32 multiply stage and the truncating output register; a full
// output does not block new requests until the two pipeline stages behind it fill.
// Registers: ramp_step at byte address 0, hold_ticks at 4; write them only
// while no request is in flight.

module linear_ramp_envelope_with_hold (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic               ramp_enable,
	input  logic               hold_level,
	input  logic signed [31:0] scale_operand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        ramp_value,
	output logic               ramp_done,
	output logic signed [31:0] scaled
);

	localparam logic REG_RAMP_STEP  = 1'b0;
	localparam logic REG_HOLD_TICKS = 1'b1;

	logic [lre_pkg::ValW-1:0] ramp_step_q;
	logic [31:0]              hold_ticks_q;
	logic                     wr_en;
	logic                     accept;
	lre_pkg::res_t            res;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q  <= '0;
			hold_ticks_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_RAMP_STEP:  ramp_step_q  <= pwdata[lre_pkg::ValW-1:0];
				REG_HOLD_TICKS: hold_ticks_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RAMP_STEP:  prdata = {15'd0, ramp_step_q};
			REG_HOLD_TICKS: prdata = hold_ticks_q;
		endcase
	end

	lre_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.ramp_enable (ramp_enable),
		.hold_level  (hold_level),
		.ramp_step   (ramp_step_q),
		.hold_ticks  (hold_ticks_q),
		.res         (res)
	);

	lre_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.res        (res),
		.operand    (scale_operand),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ramp_value (ramp_value),
		.ramp_done  (ramp_done),
		.scaled     (scaled)
	);

endmodule
